/* design/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the servo position ramp
// Request codes, register indexes, field widths and the divider handshake.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RAMP_W  = 16;
  localparam int unsigned DIVD_W  = 24;
  localparam int unsigned QUOT_W  = 16;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] PCT_MAX   = 8'd100;

  localparam logic [QUOT_W-1:0] PCT_DIVISOR   = 16'd100;
  localparam logic [QUOT_W-1:0] ANGLE_DIVISOR = 16'd180;

  // request codes
  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_HOME = 2'd2;

  // register indexes (word address)
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_CLOSED    = 3'd1;
  localparam logic [2:0] REG_OPEN      = 3'd2;
  localparam logic [2:0] REG_DUTY_ZERO = 3'd3;
  localparam logic [2:0] REG_DUTY_FULL = 3'd4;
  localparam logic [2:0] REG_RAMP_TIME = 3'd5;

  typedef struct packed {
    logic              start;
    logic              wide;      // 16 quotient bits, else 8
    logic [DIVD_W-1:0] dividend;
    logic [QUOT_W-1:0] divisor;
  } spr_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } spr_div_rsp_t;

endpackage

/* design/spr_div.sv */
// ----------------------------------------------------------------------------
// spr_div: bit-serial restoring divider
// One quotient bit per cycle; 8 or 16 quotient bits, dividend top part must
// already be below the divisor.
// ----------------------------------------------------------------------------
module spr_div import spr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  spr_div_req_t req,
  output spr_div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [QUOT_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0] low_r, low_nxt;
  logic [QUOT_W-1:0] quo_r, quo_nxt;
  logic [QUOT_W-1:0] dvs_r, dvs_nxt;

  logic [QUOT_W:0]   trial;
  logic [QUOT_W:0]   trial_diff;
  logic              fits;

  assign trial      = {rem_r, low_r[QUOT_W-1]};
  assign trial_diff = trial - {1'b0, dvs_r};
  assign fits       = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.wide ? 4'd15 : 4'd7;
      rem_nxt  = req.wide ? {8'h00, req.dividend[23:16]} : req.dividend[23:8];
      low_nxt  = req.wide ? req.dividend[15:0] : {req.dividend[7:0], 8'h00};
      quo_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_diff[QUOT_W-1:0] : trial[QUOT_W-1:0];
      low_nxt = {low_r[QUOT_W-2:0], 1'b0};
      quo_nxt = {quo_r[QUOT_W-2:0], fits};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* design/servo_position_ramp.sv */
// ----------------------------------------------------------------------------
// servo_position_ramp: linear servo ramp with PWM duty mapping
// Maps progress to a goal angle, ramps the present angle toward it on ticks
// and emits the clamped angle with its duty code.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------
//  in       | in_valid / in_ready | in_req_type, in_percent, in_now_ms
//  out      | out_valid/out_ready | out_angle, out_duty
//  config   | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
//  One word is worked on at a time by a sequencer around a shift-add
//  multiplier (one multiplier bit per cycle) and a bit-serial divider.
//  Set progress: one multiply and one divide. Ramp tick: multiply and divide
//  for the ramp, then multiply and a 16-bit divide for the duty. Home and
//  zero-ramp ticks: duty pass only. No-word ticks and ignored codes stay idle.
//  A finished word waits in the output register; a second one holds in the
//  emit step until that register is taken, and only then is input accepted.
//  Synchronous active-low reset; no clearing pass.
//
module servo_position_ramp import spr_pkg::*; #(
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [ANGLE_W-1:0]  in_percent,
  input  logic [TIME_W-1:0]   in_now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ANGLE_W-1:0]  out_angle,
  output logic [DUTY_W-1:0]   out_duty,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // bits of the duty code kept on the port
  localparam int unsigned MASK_W = (DUTY_BITS < DUTY_W) ? DUTY_BITS : DUTY_W;
  localparam logic [DUTY_W-1:0] DUTY_MASK = DUTY_W'((33'd1 << MASK_W) - 33'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_GOAL_MUL, S_GOAL_DIV, S_TICK_LOAD, S_TICK_MUL, S_RAMP_DIV,
    S_DUTY_LOAD, S_DUTY_MUL, S_DUTY_DIV, S_EMIT
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic               enable_r;
  logic [ANGLE_W-1:0] closed_r;
  logic [ANGLE_W-1:0] open_r;
  logic [DUTY_W-1:0]  duty_zero_r;
  logic [DUTY_W-1:0]  duty_full_r;
  logic [RAMP_W-1:0]  ramp_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      closed_r    <= 8'd0;
      open_r      <= 8'd180;
      duty_zero_r <= 16'd1638;
      duty_full_r <= 16'd8192;
      ramp_r      <= 16'd1000;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ENABLE:    enable_r    <= pwdata[0];
        REG_CLOSED:    closed_r    <= pwdata[ANGLE_W-1:0];
        REG_OPEN:      open_r      <= pwdata[ANGLE_W-1:0];
        REG_DUTY_ZERO: duty_zero_r <= pwdata[DUTY_W-1:0];
        REG_DUTY_FULL: duty_full_r <= pwdata[DUTY_W-1:0];
        REG_RAMP_TIME: ramp_r      <= pwdata[RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ENABLE:    prdata = 32'(enable_r);
      REG_CLOSED:    prdata = 32'(closed_r);
      REG_OPEN:      prdata = 32'(open_r);
      REG_DUTY_ZERO: prdata = 32'(duty_zero_r);
      REG_DUTY_FULL: prdata = 32'(duty_full_r);
      REG_RAMP_TIME: prdata = 32'(ramp_r);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [ANGLE_W-1:0] present_r, present_nxt;
  logic [ANGLE_W-1:0] goal_r, goal_nxt;
  logic [ANGLE_W-1:0] origin_r, origin_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ANGLE_W-1:0] out_angle_r, out_angle_nxt;
  logic [DUTY_W-1:0]  out_duty_r, out_duty_nxt;

  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [DIVD_W-1:0]  acc_r, acc_nxt;
  logic [ANGLE_W-1:0] ma_r, ma_nxt;
  logic [ANGLE_W-1:0] mb_r, mb_nxt;
  logic [QUOT_W-1:0]  mx_r, mx_nxt;
  logic [QUOT_W-1:0]  my_r, my_nxt;
  logic [2:0]         mcnt_r, mcnt_nxt;
  logic               neg_r, neg_nxt;
  logic [ANGLE_W-1:0] ang_r, ang_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic               in_fire;
  logic [ANGLE_W-1:0] pct_sat;
  logic [ANGLE_W:0]   open_diff;
  logic [ANGLE_W:0]   open_mag;
  logic [DUTY_W:0]    duty_diff;
  logic [DUTY_W:0]    duty_mag;
  logic [DIVD_W-1:0]  acc_step;
  logic               mul_last;
  logic [RAMP_W-1:0]  ramp_m;
  logic [ANGLE_W-1:0] ang_clamp;
  logic [ANGLE_W-1:0] div_q8;
  logic [ANGLE_W-1:0] goal_calc;
  logic [DUTY_W-1:0]  duty_calc;

  spr_div_req_t div_req;
  spr_div_rsp_t div_rsp;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;

  // saturate progress to one hundred percent
  assign pct_sat = (in_percent > PCT_MAX) ? PCT_MAX : in_percent;

  // signed spans go through the multiplier as magnitude plus sign
  assign open_diff = {1'b0, open_r} - {1'b0, closed_r};
  assign open_mag  = open_diff[ANGLE_W] ? (~open_diff + 9'd1) : open_diff;
  assign duty_diff = {1'b0, duty_full_r} - {1'b0, duty_zero_r};
  assign duty_mag  = duty_diff[DUTY_W] ? (~duty_diff + 17'd1) : duty_diff;

  // shift-add step, MSB of the multiplier bits first; two products summed
  assign acc_step = {acc_r[DIVD_W-2:0], 1'b0}
                  + (ma_r[ANGLE_W-1] ? DIVD_W'(mx_r) : '0)
                  + (mb_r[ANGLE_W-1] ? DIVD_W'(my_r) : '0);
  assign mul_last = (mcnt_r == 3'd0);

  // time into the ramp, held at the full ramp time
  assign ramp_m    = (elapsed_r < TIME_W'(ramp_r)) ? elapsed_r[RAMP_W-1:0] : ramp_r;
  assign ang_clamp = (ang_r > ANGLE_MAX) ? ANGLE_MAX : ang_r;

  assign div_q8    = div_rsp.quotient[ANGLE_W-1:0];
  assign goal_calc = neg_r ? (closed_r - div_q8) : (closed_r + div_q8);
  assign duty_calc = neg_r ? (duty_zero_r - div_rsp.quotient)
                           : (duty_zero_r + div_rsp.quotient);

  // launch the divide on the last multiply step
  always_comb begin
    div_req.start    = mul_last && (state_r == S_GOAL_MUL || state_r == S_TICK_MUL ||
                                    state_r == S_DUTY_MUL);
    div_req.wide     = (state_r == S_DUTY_MUL);
    div_req.dividend = acc_step;
    case (state_r)
      S_GOAL_MUL: div_req.divisor = PCT_DIVISOR;
      S_TICK_MUL: div_req.divisor = ramp_r;
      default:    div_req.divisor = ANGLE_DIVISOR;
    endcase
  end

  spr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    goal_nxt      = goal_r;
    origin_nxt    = origin_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r;
    out_angle_nxt = out_angle_r;
    out_duty_nxt  = out_duty_r;
    now_nxt       = now_r;
    elapsed_nxt   = elapsed_r;
    acc_nxt       = acc_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    mcnt_nxt      = mcnt_r;
    neg_nxt       = neg_r;
    ang_nxt       = ang_r;
    duty_nxt      = duty_r;

    // drop the output word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          now_nxt = in_now_ms;
          case (in_req_type)
            REQ_SET: begin
              // |open - closed| * pct, then divide by 100
              neg_nxt   = open_diff[ANGLE_W];
              mx_nxt    = QUOT_W'(open_mag[ANGLE_W-1:0]);
              my_nxt    = '0;
              ma_nxt    = pct_sat;
              mb_nxt    = '0;
              acc_nxt   = '0;
              mcnt_nxt  = 3'd7;
              state_nxt = S_GOAL_MUL;
            end
            REQ_TICK: begin
              if (enable_r && (present_r != goal_r)) begin
                if (ramp_r == '0) begin
                  // zero ramp time: jump to the goal
                  present_nxt = goal_r;
                  ang_nxt     = goal_r;
                  state_nxt   = S_DUTY_LOAD;
                end else begin
                  elapsed_nxt = in_now_ms - start_r;
                  state_nxt   = S_TICK_LOAD;
                end
              end
            end
            REQ_HOME: begin
              if (enable_r) begin
                present_nxt = closed_r;
                goal_nxt    = closed_r;
                origin_nxt  = closed_r;
                ang_nxt     = closed_r;
                state_nxt   = S_DUTY_LOAD;
              end
            end
            default: ;
          endcase
        end
      end

      S_GOAL_MUL, S_TICK_MUL, S_DUTY_MUL: begin
        acc_nxt  = acc_step;
        ma_nxt   = {ma_r[ANGLE_W-2:0], 1'b0};
        mb_nxt   = {mb_r[ANGLE_W-2:0], 1'b0};
        mcnt_nxt = mcnt_r - 3'd1;
        if (mul_last) begin
          case (state_r)
            S_GOAL_MUL: state_nxt = S_GOAL_DIV;
            S_TICK_MUL: state_nxt = S_RAMP_DIV;
            default:    state_nxt = S_DUTY_DIV;
          endcase
        end
      end

      S_GOAL_DIV: begin
        if (div_rsp.done) begin
          // restart the ramp only on a new goal
          if (goal_calc != goal_r) begin
            origin_nxt = present_r;
            goal_nxt   = goal_calc;
            start_nxt  = now_r;
          end
          state_nxt = S_IDLE;
        end
      end

      S_TICK_LOAD: begin
        // origin*(T-m) + goal*m, then divide by T
        mx_nxt    = ramp_r - ramp_m;
        my_nxt    = ramp_m;
        ma_nxt    = origin_r;
        mb_nxt    = goal_r;
        acc_nxt   = '0;
        mcnt_nxt  = 3'd7;
        state_nxt = S_TICK_MUL;
      end

      S_RAMP_DIV: begin
        if (div_rsp.done) begin
          present_nxt = div_q8;
          ang_nxt     = div_q8;
          state_nxt   = S_DUTY_LOAD;
        end
      end

      S_DUTY_LOAD: begin
        // clamped angle * |full - zero|, then divide by 180
        ang_nxt   = ang_clamp;
        neg_nxt   = duty_diff[DUTY_W];
        mx_nxt    = duty_mag[DUTY_W-1:0];
        my_nxt    = '0;
        ma_nxt    = ang_clamp;
        mb_nxt    = '0;
        acc_nxt   = '0;
        mcnt_nxt  = 3'd7;
        state_nxt = S_DUTY_MUL;
      end

      S_DUTY_DIV: begin
        if (div_rsp.done) begin
          duty_nxt  = duty_calc;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = ang_r;
          out_duty_nxt  = duty_r & DUTY_MASK;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      goal_r      <= '0;
      origin_r    <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
      out_angle_r <= '0;
      out_duty_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      goal_r      <= goal_nxt;
      origin_r    <= origin_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      out_angle_r <= out_angle_nxt;
      out_duty_r  <= out_duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    elapsed_r <= elapsed_nxt;
    acc_r     <= acc_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    mcnt_r    <= mcnt_nxt;
    neg_r     <= neg_nxt;
    ang_r     <= ang_nxt;
    duty_r    <= duty_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;
  assign out_duty  = out_duty_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // a divide only finishes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_GOAL_DIV || state_r == S_RAMP_DIV ||
                      state_r == S_DUTY_DIV))
    else $error("divider result with no waiting step");

  // no new word while the divider still runs
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !div_rsp.busy)
    else $error("input word taken during a divide");

  // a ramp angle lies between the ramp origin and the goal
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RAMP_DIV && div_rsp.done) |->
      (div_rsp.quotient[QUOT_W-1:ANGLE_W] == '0) &&
      ((div_q8 >= origin_r && div_q8 <= goal_r) ||
       (div_q8 <= origin_r && div_q8 >= goal_r)))
    else $error("ramp angle outside origin and goal");

  // emitted angle is clamped
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_angle_r <= ANGLE_MAX))
    else $error("emitted angle above limit");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for servo_position_ramp
// Drives progress, tick and home words through the valid/ready input, keeps
// its own ramp and duty predictor, and compares every output word in order.
// Runs directed corner cases, back-pressure and pause stretches, then random
// ramp sequences under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench import spr_pkg::*; ();

  localparam int unsigned DUTY_BITS     = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 64;
  // request code the block must ignore
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [DUTY_W-1:0]  duty;
  } servo_word_t;

  // DUT connections
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_req_type;
  logic [ANGLE_W-1:0]  in_percent;
  logic [TIME_W-1:0]   in_now_ms;
  logic                out_valid;
  logic                out_ready;
  logic [ANGLE_W-1:0]  out_angle;
  logic [DUTY_W-1:0]   out_duty;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [4:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Predictor copy of the registers
  logic                en_copy;
  logic [ANGLE_W-1:0]  closed_deg;
  logic [ANGLE_W-1:0]  open_deg;
  logic [DUTY_W-1:0]   duty_lo;    // duty code at 0 degrees
  logic [DUTY_W-1:0]   duty_hi;    // duty code at 180 degrees
  logic [RAMP_W-1:0]   ramp_ms;

  // Predictor copy of the ramp state
  logic [ANGLE_W-1:0]  cur_deg;
  logic [ANGLE_W-1:0]  goal_deg;
  logic [ANGLE_W-1:0]  origin_deg;
  logic [TIME_W-1:0]   ramp_t0;

  servo_word_t         pending_words[$];   // expected output words, oldest first
  int unsigned         err_count;
  int unsigned         cycle_count;
  int unsigned         snd_idle_pct;
  int unsigned         rcv_stall_pct;
  int                  hold_left;          // receiver hold-off, in cycles
  logic [TIME_W-1:0]   tb_now;             // running millisecond clock of the stimulus

  servo_position_ramp #(
    .DUTY_BITS(DUTY_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .in_percent (in_percent),
    .in_now_ms  (in_now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_angle  (out_angle),
    .out_duty   (out_duty),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: end the run if the traffic never drains.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off completely while hold_left runs.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Output checker. Sample mid-cycle: valid and ready seen here are what the
  // next rising edge will use, so the word is accepted at that edge.
  always @(negedge clk) begin
    servo_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word: expected none, got angle %0d duty %0d",
                 $time, out_angle, out_duty);
      end else begin
        want = pending_words.pop_front();
        if (out_angle !== want.angle) begin
          err_count++;
          $display("%0t: angle mismatch: expected %0d, got %0d",
                   $time, want.angle, out_angle);
        end
        if (out_duty !== want.duty) begin
          err_count++;
          $display("%0t: duty mismatch: expected %0d, got %0d",
                   $time, want.duty, out_duty);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Clamp the angle to 180 and map it onto the duty line between duty_lo and
  // duty_hi; signed division truncates toward zero, as the block does.
  function automatic servo_word_t angle_to_word(logic [ANGLE_W-1:0] deg);
    longint      a;
    longint      d;
    servo_word_t w;
    a = (deg > ANGLE_MAX) ? longint'(ANGLE_MAX) : longint'(deg);
    d = longint'(duty_lo) + (a * (longint'(duty_hi) - longint'(duty_lo))) / 180;
    d = d & ((longint'(1) << DUTY_BITS) - 1);
    w.angle = a[ANGLE_W-1:0];
    w.duty  = d[DUTY_W-1:0];
    return w;
  endfunction

  // Advance the predicted ramp by one accepted input word and queue its
  // output word, if it causes one.
  function automatic void track_ramp(logic [1:0] req, logic [7:0] pct,
                                     logic [TIME_W-1:0] now);
    longint            c;
    longint            o;
    longint            p;
    longint            s;
    longint            g;
    longint            t;
    longint            m;
    longint            num;
    logic [TIME_W-1:0] elapsed;
    logic [ANGLE_W-1:0] nxt;
    case (req)
      REQ_SET: begin
        // saturate to 100 %, then interpolate closed..open
        p   = (pct > PCT_MAX) ? longint'(PCT_MAX) : longint'(pct);
        c   = longint'(closed_deg);
        o   = longint'(open_deg);
        num = c + ((o - c) * p) / 100;
        nxt = num[ANGLE_W-1:0];
        // restart the ramp only on a new goal
        if (nxt != goal_deg) begin
          origin_deg = cur_deg;
          goal_deg   = nxt;
          ramp_t0    = now;
        end
      end
      REQ_TICK: begin
        if (en_copy && cur_deg != goal_deg) begin
          elapsed = now - ramp_t0;   // wraps modulo 2^32
          if (ramp_ms == '0) begin
            nxt = goal_deg;          // zero ramp time: jump
          end else begin
            t   = longint'(ramp_ms);
            m   = (elapsed < TIME_W'(ramp_ms)) ? longint'(elapsed) : longint'(ramp_ms);
            s   = longint'(origin_deg);
            g   = longint'(goal_deg);
            num = (s * t + (g - s) * m) / t;
            nxt = num[ANGLE_W-1:0];
          end
          cur_deg = nxt;
          pending_words.push_back(angle_to_word(nxt));
        end
      end
      REQ_HOME: begin
        // home leaves the ramp start time alone
        if (en_copy) begin
          cur_deg    = closed_deg;
          goal_deg   = closed_deg;
          origin_deg = closed_deg;
          pending_words.push_back(angle_to_word(closed_deg));
        end
      end
      default: ;   // unused code: ignored
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one word and hold it until accepted. Entered and left at a rising
  // edge; valid stays high on return so back-to-back words need no gap.
  task automatic send_word(logic [1:0] req, logic [7:0] pct, logic [TIME_W-1:0] now);
    bit taken;
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_percent  <= pct;
    in_now_ms   <= now;
    taken = 1'b0;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    track_ramp(req, pct, now);
  endtask

  // Drop valid and wait for a rising edge so the next drive lands in a new step.
  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every expected word, then let a word that causes no output finish.
  task automatic wait_idle();
    release_input();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, access cycle, then the bus goes idle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ENABLE:    en_copy    = val[0];
      REG_CLOSED:    closed_deg = val[ANGLE_W-1:0];
      REG_OPEN:      open_deg   = val[ANGLE_W-1:0];
      REG_DUTY_ZERO: duty_lo    = val[DUTY_W-1:0];
      REG_DUTY_FULL: duty_hi    = val[DUTY_W-1:0];
      REG_RAMP_TIME: ramp_ms    = val[RAMP_W-1:0];
      default: ;
    endcase
  endtask

  // Program all six registers in one go.
  task automatic write_setup(logic en, logic [7:0] closed_v, logic [7:0] open_v,
                             logic [15:0] lo_v, logic [15:0] hi_v, logic [15:0] ramp_v);
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_CLOSED, 32'(closed_v));
    write_reg(REG_OPEN, 32'(open_v));
    write_reg(REG_DUTY_ZERO, 32'(lo_v));
    write_reg(REG_DUTY_FULL, 32'(hi_v));
    write_reg(REG_RAMP_TIME, 32'(ramp_v));
  endtask

  // --------------------------------------------------------------------------
  // Random pickers, weighted toward the edges
  // --------------------------------------------------------------------------

  function automatic logic [7:0] pick_angle();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return ANGLE_MAX;
      2:       return 8'($urandom_range(181, 255));
      default: return 8'($urandom_range(0, 180));
    endcase
  endfunction

  function automatic logic [15:0] pick_duty();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Keep most ramps short so sequences reach their goal.
  function automatic logic [15:0] pick_ramp();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'($urandom_range(1000, 65535));
      default: return 16'($urandom_range(2, 300));
    endcase
  endfunction

  function automatic logic [7:0] pick_percent();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return PCT_MAX;
      2:       return 8'($urandom_range(101, 255));
      default: return 8'($urandom_range(0, 100));
    endcase
  endfunction

  // Mostly well-formed ramps (a new goal, then ticks with advancing time),
  // the rest noise: any code, any percent, time jumps anywhere.
  task automatic run_random(int unsigned n, int unsigned snd_pct, int unsigned rcv_pct);
    int unsigned       sent;
    int unsigned       step_max;
    logic [1:0]        req;
    logic [TIME_W-1:0] now;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    // start some phases just below the time wrap
    if ($urandom_range(3) == 0) tb_now = 32'hFFFF_FF00 + $urandom_range(255);
    else tb_now = $urandom();
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        send_word(REQ_SET, pick_percent(), tb_now);
        sent++;
        step_max = 32'(ramp_ms) / 3 + 2;
        repeat ($urandom_range(2, 10)) begin
          tb_now += $urandom_range(0, step_max);
          if ($urandom_range(19) == 0)
            send_word(REQ_HOME, 8'($urandom_range(255)), tb_now);
          else
            send_word(REQ_TICK, 8'($urandom_range(255)), tb_now);
          sent++;
        end
      end else begin
        req = 2'($urandom_range(3));
        now = $urandom_range(1) ? $urandom() : tb_now + $urandom_range(5000);
        send_word(req, 8'($urandom_range(255)), now);
        if (req != REQ_UNUSED) sent++;
      end
    end
    release_input();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: a full ramp, no-move ticks, saturation, home, the unused
  // code and a ramp whose elapsed time wraps past 2^32.
  task automatic test_ramp_basics();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_word(REQ_TICK, 8'd0, 32'd5);             // at goal: no word
    send_word(REQ_SET, 8'd0, 32'd0);              // same goal: no restart
    send_word(REQ_SET, 8'd50, 32'd100);           // goal 90
    send_word(REQ_TICK, 8'd0, 32'd100);           // ramp start
    send_word(REQ_TICK, 8'd0, 32'd600);           // half way
    send_word(REQ_TICK, 8'd0, 32'd1100);          // reach goal
    send_word(REQ_TICK, 8'd0, 32'd1200);          // at goal: no word
    send_word(REQ_SET, 8'd255, 32'd1300);         // saturate to 100 %
    send_word(REQ_TICK, 8'd0, 32'd3300);          // past the ramp time
    send_word(REQ_SET, PCT_MAX, 32'd3400);        // unchanged goal
    send_word(REQ_HOME, 8'd0, 32'd3500);
    send_word(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF);  // ignored
    send_word(REQ_SET, 8'd1, 32'hFFFF_FFF0);      // goal 1, start near wrap
    send_word(REQ_TICK, 8'd0, 32'h0000_01F0);     // elapsed wraps to 512
    send_word(REQ_TICK, 8'd0, 32'h0000_03E0);     // elapsed 1008: done
    wait_idle();
  endtask

  // Reversed angles, inverted duty line, zero ramp time, angles above 180,
  // the disabled block and the longest ramp.
  task automatic test_special_cases();
    write_setup(1'b1, ANGLE_MAX, 8'd0, 16'hFFFF, 16'd0, 16'd0);
    send_word(REQ_HOME, 8'd0, 32'd10);            // home to 180, duty 0
    send_word(REQ_SET, 8'd37, 32'd20);            // downward goal
    send_word(REQ_TICK, 8'd0, 32'd20);            // zero ramp time: jump
    send_word(REQ_SET, PCT_MAX, 32'd30);
    send_word(REQ_TICK, 8'd0, 32'd30);
    wait_idle();
    // angles above 180 ramp as given; only the output clamps
    write_setup(1'b1, 8'd200, 8'd255, 16'd0, 16'hFFFF, 16'd3);
    send_word(REQ_HOME, 8'd0, 32'd40);
    send_word(REQ_SET, PCT_MAX, 32'd50);
    send_word(REQ_TICK, 8'd0, 32'd51);
    send_word(REQ_TICK, 8'd0, 32'd55);
    wait_idle();
    // disabled: ticks and home stay silent
    write_reg(REG_ENABLE, 32'd0);
    send_word(REQ_SET, 8'd0, 32'd60);
    send_word(REQ_TICK, 8'd0, 32'd61);
    send_word(REQ_HOME, 8'd0, 32'd62);
    wait_idle();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_RAMP_TIME, 32'h0000_FFFF);
    send_word(REQ_TICK, 8'd0, 32'd40000);         // resumes the pending ramp
    send_word(REQ_TICK, 8'd0, 32'd70000);
    wait_idle();
  endtask

  // Hold the receiver off for a long stretch while ticks keep coming, so
  // the output register fills and the input stalls.
  task automatic test_backpressure();
    write_setup(1'b1, 8'd0, ANGLE_MAX, 16'd1638, 16'd8192, 16'd60000);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    tb_now = 32'd1000;
    send_word(REQ_HOME, 8'd0, tb_now);
    send_word(REQ_SET, PCT_MAX, tb_now);
    hold_left = 400;
    repeat (40) begin
      tb_now += $urandom_range(1, 500);
      send_word(REQ_TICK, 8'd0, tb_now);
    end
    wait_idle();
  endtask

  // Pause the sender until every expected word has come, then resume
  // mid-ramp with a slow receiver.
  task automatic test_sender_pause();
    rcv_stall_pct = 50;
    repeat (3) begin
      repeat (8) begin
        tb_now += $urandom_range(1, 800);
        send_word(REQ_TICK, 8'($urandom_range(255)), tb_now);
      end
      release_input();
      while (pending_words.size() != 0) @(posedge clk);
    end
    wait_idle();
  endtask

  // Random ramps over several register settings and idling patterns.
  task automatic test_random_traffic();
    int unsigned idle_mix[5][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{21, 21}, '{0, 0}};
    int unsigned sizes[5]       = '{300, 300, 300, 300, 250};
    for (int i = 0; i < 5; i++) begin
      write_setup(1'b1, pick_angle(), pick_angle(), pick_duty(), pick_duty(), pick_ramp());
      run_random(sizes[i], idle_mix[i][0], idle_mix[i][1]);
      wait_idle();
    end
    // extremes: top-of-range angles, full duty span, longest ramp
    write_setup(1'b1, 8'd255, 8'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(100, 0, 0);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // known values on every input from time zero
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_SET;
    in_percent    = '0;
    in_now_ms     = '0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    err_count     = 0;
    cycle_count   = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_left     = 0;
    tb_now        = '0;
    // predictor starts from the reset values
    en_copy    = 1'b1;
    closed_deg = 8'd0;
    open_deg   = ANGLE_MAX;
    duty_lo    = 16'd1638;
    duty_hi    = 16'd8192;
    ramp_ms    = 16'd1000;
    cur_deg    = '0;
    goal_deg   = '0;
    origin_deg = '0;
    ramp_t0    = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ramp_basics();
    test_special_cases();
    test_backpressure();
    test_sender_pause();
    test_random_traffic();

    // drain, then give a trailing word time to show up
    release_input();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
design/spr_pkg.sv
design/spr_div.sv
design/servo_position_ramp.sv
test/testbench.sv
